[rtl/deq_pkg.sv]
package deq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned SumW     = CntW + 1;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HeldW    = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic signed [DataW-1:0] data_out;
    logic [HeldW-1:0]   entries_held;
    logic               last;
  } res_t;

  // ring position of a sum that stays below twice the depth
  function automatic logic [AddrW-1:0] wrap_idx(input logic [SumW-1:0] x);
    logic [SumW-1:0] r;
    r = (x >= SumW'(Depth)) ? (x - SumW'(Depth)) : x;
    return r[AddrW-1:0];
  endfunction

endpackage

[rtl/deq_ram.sv]
module deq_ram #(
  parameter int unsigned Width = deq_pkg::DataW,
  parameter int unsigned Depth = deq_pkg::Depth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/double_ended_queue.sv]
// push, pop and unknown commands: result in the cycle after the transfer; one command
//   per cycle while busy is low
// listing: one entry per cycle from the single ram read port, results start in the cycle
//   after the transfer; busy stays high until the read of the last entry is issued
// results are shown for one cycle with strobe_o; the receiver cannot stall
// reset (asynchronous, active low) empties the queue; ram contents are left as they are
module double_ended_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  deq_pkg::req_t   req_i,
  output logic            strobe_o,
  output deq_pkg::res_t   res_o
);

  localparam int unsigned AddrW = deq_pkg::AddrW;
  localparam int unsigned CntW  = deq_pkg::CntW;
  localparam int unsigned SumW  = deq_pkg::SumW;

  logic                 accept;
  logic [AddrW-1:0]     front_q, front_d;
  logic [CntW-1:0]      occ_q, occ_d;
  logic                 list_q, list_d;
  logic [AddrW-1:0]     idx_q, idx_d;

  logic                 res_valid_q, res_valid_d;
  deq_pkg::status_e     status_q, status_d;
  logic [CntW-1:0]      held_q, held_d;
  logic                 last_q, last_d;
  logic                 use_rd_q, use_rd_d;

  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic                 re;
  logic [AddrW-1:0]     raddr;
  logic [deq_pkg::DataW-1:0] rdata;

  logic                 full;
  logic                 empty;

  assign accept = start & ~busy;
  assign busy   = list_q;
  assign full   = (occ_q == CntW'(deq_pkg::Depth));
  assign empty  = (occ_q == '0);

  always_comb begin
    front_d     = front_q;
    occ_d       = occ_q;
    list_d      = list_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    status_d    = deq_pkg::ST_OK;
    held_d      = occ_q;
    last_d      = 1'b1;
    use_rd_d    = 1'b0;
    we          = 1'b0;
    waddr       = front_q;
    re          = 1'b0;
    raddr       = front_q;

    if (list_q) begin
      re          = 1'b1;
      raddr       = deq_pkg::wrap_idx(SumW'(front_q) + SumW'(idx_q));
      res_valid_d = 1'b1;
      use_rd_d    = 1'b1;
      last_d      = (CntW'(idx_q) == occ_q - CntW'(1));
      if (last_d) begin
        list_d = 1'b0;
      end else begin
        idx_d = idx_q + AddrW'(1);
      end
    end else if (accept) begin
      res_valid_d = 1'b1;
      case (deq_pkg::cmd_e'(req_i.command))
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_d = deq_pkg::ST_FULL;
          end else begin
            we = 1'b1;
            if (req_i.command == deq_pkg::CMD_PUSH_FRONT) begin
              front_d = deq_pkg::wrap_idx(SumW'(front_q) + SumW'(deq_pkg::Depth - 1));
              waddr   = front_d;
            end else begin
              waddr = deq_pkg::wrap_idx(SumW'(front_q) + SumW'(occ_q));
            end
            occ_d  = occ_q + CntW'(1);
            held_d = occ_d;
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            re       = 1'b1;
            use_rd_d = 1'b1;
            if (req_i.command == deq_pkg::CMD_POP_FRONT) begin
              raddr   = front_q;
              front_d = deq_pkg::wrap_idx(SumW'(front_q) + SumW'(1));
            end else begin
              raddr = deq_pkg::wrap_idx(SumW'(front_q) + SumW'(occ_q) - SumW'(1));
            end
            occ_d  = occ_q - CntW'(1);
            held_d = occ_d;
          end
        end
        deq_pkg::CMD_LIST: begin
          if (empty) begin
            status_d = deq_pkg::ST_EMPTY;
          end else begin
            re       = 1'b1;
            raddr    = front_q;
            use_rd_d = 1'b1;
            last_d   = (occ_q == CntW'(1));
            if (!last_d) begin
              list_d = 1'b1;
              idx_d  = AddrW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      occ_q       <= '0;
      list_q      <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      occ_q       <= occ_d;
      list_q      <= list_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    held_q   <= held_d;
    last_q   <= last_d;
    use_rd_q <= use_rd_d;
  end

  deq_ram #(
    .Width (deq_pkg::DataW),
    .Depth (deq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign strobe_o           = res_valid_q;
  assign res_o.status       = status_q;
  assign res_o.data_out     = use_rd_q ? rdata : '0;
  assign res_o.entries_held = deq_pkg::HeldW'(held_q);
  assign res_o.last         = last_q;

endmodule
